// File: design/gpl_pkg.sv
// gpl_pkg: widths, constants, state and command types for the grid path length block.
// No dependencies; every other file of the block uses it.
package gpl_pkg;

   localparam int COORD_BITS = 16;
   localparam int DELTA_BITS = COORD_BITS + 1;
   localparam int MAG_BITS   = COORD_BITS;
   localparam int LAYER_BITS = 8;
   localparam int RES_BITS   = 24;
   localparam int TOTAL_BITS = 48;
   localparam int MUL_BITS   = 32;
   localparam int PROD_BITS  = 2 * MUL_BITS;
   localparam int D2_BITS    = 2 * MAG_BITS + 1;
   localparam int RES2_BITS  = 2 * RES_BITS;
   localparam int RAD_BITS   = 82;
   localparam int ROOT_BITS  = RAD_BITS / 2;
   localparam int REM_BITS   = ROOT_BITS + 2;
   localparam int BEND_BITS  = 57;
   localparam int SQRT_STEPS = ROOT_BITS;
   localparam int CNT_BITS   = $clog2(SQRT_STEPS);

   localparam logic [RES_BITS-1:0]   RES_RESET  = 24'd65536;
   localparam logic [TOTAL_BITS-1:0] TOTAL_MAX  = 48'hFFFF_FFFF_FFFF;
   // pi/2 in Q32 is 1.921FB544 hex; the integer one is added separately
   localparam logic [MUL_BITS-1:0]   HALF_PI_LO = 32'h921F_B544;
   localparam logic [BEND_BITS-1:0]  BEND_ROUND = 57'd2147483648;
   localparam logic [CNT_BITS-1:0]   SQRT_LAST  = CNT_BITS'(SQRT_STEPS - 1);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECIDE,
      S_SQX,
      S_SQY,
      S_RR,
      S_NLO,
      S_NHI,
      S_NACC,
      S_SQRT,
      S_BMUL,
      S_BADD,
      S_ADD,
      S_UPDATE
   } gpl_state_type;

   typedef enum logic [2:0] {
      MUL_NONE,
      MUL_XX,
      MUL_YY,
      MUL_RR,
      MUL_NLO,
      MUL_NHI,
      MUL_BEND
   } gpl_mul_type;

   typedef struct packed {
      gpl_mul_type mul_sel;
      logic        load;
      logic        take_step;
      logic        d2_load;
      logic        d2_add;
      logic        res2_load;
      logic        rad_lo;
      logic        rad_hi;
      logic        sqrt_step;
      logic        bend_load;
      logic        add_step;
      logic        update;
      logic        emit;
   } gpl_cmd_type;

   typedef struct packed {
      logic first_point;
      logic via;
      logic bend;
      logic last_point;
   } gpl_status_type;

endpackage

// File: design/gpl_ifs.sv
// gpl_ifs: request and response channel interfaces (valid/ready plus payload).
// Depends on gpl_pkg for field widths.
interface gpl_req_if;
   logic                              valid;
   logic                              ready;
   logic [gpl_pkg::COORD_BITS-1:0]    x;
   logic [gpl_pkg::COORD_BITS-1:0]    y;
   logic [gpl_pkg::LAYER_BITS-1:0]    layer;
   logic                              last_point;

   modport source (output valid, output x, output y, output layer, output last_point,
                   input ready);
   modport sink   (input valid, input x, input y, input layer, input last_point,
                   output ready);
endinterface

interface gpl_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [gpl_pkg::TOTAL_BITS-1:0]    length_q16;
   logic                              saturated;

   modport source (output valid, output length_q16, output saturated, input ready);
   modport sink   (input valid, input length_q16, input saturated, output ready);
endinterface

// File: design/gpl_datapath.sv
// gpl_datapath: path state, shared 32x32 multiplier, bit-pair square root and total.
// Depends on gpl_pkg; driven by gpl_ctrl through gpl_cmd_type.
module gpl_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  gpl_pkg::gpl_cmd_type            cmd,
   output gpl_pkg::gpl_status_type         status,
   input  logic [gpl_pkg::COORD_BITS-1:0]  req_x,
   input  logic [gpl_pkg::COORD_BITS-1:0]  req_y,
   input  logic [gpl_pkg::LAYER_BITS-1:0]  req_layer,
   input  logic                            req_last_point,
   input  logic                            csr_we,
   input  logic [gpl_pkg::RES_BITS-1:0]    csr_wdata,
   output logic [gpl_pkg::TOTAL_BITS-1:0]  rsp_length_q16,
   output logic                            rsp_saturated
);
   import gpl_pkg::*;

   logic [COORD_BITS-1:0]        cur_x_ff, cur_y_ff, prev_x_ff, prev_y_ff;
   logic [LAYER_BITS-1:0]        cur_layer_ff, prev_layer_ff;
   logic                         cur_last_ff;
   logic signed [DELTA_BITS-1:0] pstep_dx_ff, pstep_dy_ff, step_dx_ff, step_dy_ff;
   logic signed [DELTA_BITS-1:0] dx, dy, abs_dx, abs_dy;
   logic [MAG_BITS-1:0]          mag_x_ff, mag_y_ff;
   logic [1:0]                   points_ff, points_in;
   logic [RES_BITS-1:0]          res_ff;
   logic [MUL_BITS-1:0]          mul_a, mul_b;
   logic [PROD_BITS-1:0]         prod_ff;
   logic [D2_BITS-1:0]           d2_ff;
   logic [RES2_BITS-1:0]         res2_ff;
   logic [RAD_BITS-1:0]          rad_ff;
   logic [ROOT_BITS-1:0]         root_ff;
   logic [REM_BITS-1:0]          rem_ff;
   logic [REM_BITS+1:0]          rem_sh, trial, rem_diff;
   logic [BEND_BITS-1:0]         bend_sum;
   logic [TOTAL_BITS:0]          sum;
   logic [TOTAL_BITS-1:0]        total_ff, total_in, rsp_len_ff;
   logic                         clamp_ff, clamp_in, rsp_sat_ff;
   logic                         same_x, same_y;

   // step deltas and classification
   assign dx     = $signed({1'b0, cur_x_ff}) - $signed({1'b0, prev_x_ff});
   assign dy     = $signed({1'b0, cur_y_ff}) - $signed({1'b0, prev_y_ff});
   assign abs_dx = dx[DELTA_BITS-1] ? -dx : dx;
   assign abs_dy = dy[DELTA_BITS-1] ? -dy : dy;
   assign same_x = (cur_x_ff == prev_x_ff);
   assign same_y = (cur_y_ff == prev_y_ff);

   always_comb begin
      status.first_point = (points_ff == 2'd0);
      status.via         = (cur_layer_ff != prev_layer_ff);
      status.bend        = (points_ff == 2'd2) &&
                           (((pstep_dx_ff != '0) && !same_y && same_x && (pstep_dy_ff == '0)) ||
                            ((pstep_dy_ff != '0) && !same_x && same_y && (pstep_dx_ff == '0)));
      status.last_point  = cur_last_ff;
   end

   // shared multiplier operand select
   always_comb begin
      case (cmd.mul_sel)
         MUL_XX: begin
            mul_a = MUL_BITS'(mag_x_ff);
            mul_b = MUL_BITS'(mag_x_ff);
         end
         MUL_YY: begin
            mul_a = MUL_BITS'(mag_y_ff);
            mul_b = MUL_BITS'(mag_y_ff);
         end
         MUL_RR: begin
            mul_a = MUL_BITS'(res_ff);
            mul_b = MUL_BITS'(res_ff);
         end
         MUL_NLO: begin
            mul_a = MUL_BITS'(prod_ff[RES2_BITS/2-1:0]);
            mul_b = d2_ff[MUL_BITS-1:0];
         end
         MUL_NHI: begin
            mul_a = MUL_BITS'(res2_ff[RES2_BITS-1:RES2_BITS/2]);
            mul_b = d2_ff[MUL_BITS-1:0];
         end
         MUL_BEND: begin
            mul_a = MUL_BITS'(res_ff);
            mul_b = HALF_PI_LO;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // one root bit per cycle, radicand consumed two bits at a time from the top
   assign rem_sh   = {rem_ff, rad_ff[RAD_BITS-1:RAD_BITS-2]};
   assign trial    = (REM_BITS+2)'({root_ff, 2'b01});
   assign rem_diff = rem_sh - trial;

   assign bend_sum = {1'b0, prod_ff[BEND_BITS-2:0]} + BEND_ROUND;
   assign sum      = {1'b0, total_ff} + (TOTAL_BITS+1)'(root_ff);

   always_comb begin
      points_in = (points_ff == 2'd2) ? 2'd2 : points_ff + 2'd1;
      total_in  = total_ff;
      clamp_in  = clamp_ff;
      if (cmd.add_step) begin
         if (sum[TOTAL_BITS]) begin
            total_in = TOTAL_MAX;
            clamp_in = 1'b1;
         end else begin
            total_in = sum[TOTAL_BITS-1:0];
         end
      end
   end

   // control and path state
   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff    <= RES_RESET;
         points_ff <= 2'd0;
         total_ff  <= '0;
         clamp_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            res_ff <= csr_wdata;
         end
         if (cmd.emit) begin
            points_ff <= 2'd0;
            total_ff  <= '0;
            clamp_ff  <= 1'b0;
         end else begin
            if (cmd.update) begin
               points_ff <= points_in;
            end
            total_ff <= total_in;
            clamp_ff <= clamp_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      if (cmd.load) begin
         cur_x_ff     <= req_x;
         cur_y_ff     <= req_y;
         cur_layer_ff <= req_layer;
         cur_last_ff  <= req_last_point;
      end
      if (cmd.take_step) begin
         step_dx_ff <= dx;
         step_dy_ff <= dy;
         mag_x_ff   <= abs_dx[MAG_BITS-1:0];
         mag_y_ff   <= abs_dy[MAG_BITS-1:0];
      end
      if (cmd.update) begin
         prev_x_ff     <= cur_x_ff;
         prev_y_ff     <= cur_y_ff;
         prev_layer_ff <= cur_layer_ff;
         if (points_ff != 2'd0) begin
            pstep_dx_ff <= step_dx_ff;
            pstep_dy_ff <= step_dy_ff;
         end
      end
      if (cmd.d2_load) begin
         d2_ff <= prod_ff[D2_BITS-1:0];
      end
      if (cmd.d2_add) begin
         d2_ff <= d2_ff + prod_ff[D2_BITS-1:0];
      end
      if (cmd.res2_load) begin
         res2_ff <= prod_ff[RES2_BITS-1:0];
      end
      if (cmd.rad_lo) begin
         rad_ff  <= RAD_BITS'(prod_ff[BEND_BITS-2:0]) +
                    (d2_ff[D2_BITS-1] ? RAD_BITS'({res2_ff, 32'd0}) : '0);
         root_ff <= '0;
         rem_ff  <= '0;
      end
      if (cmd.rad_hi) begin
         rad_ff <= rad_ff + RAD_BITS'({prod_ff[BEND_BITS-2:0], 24'd0});
      end
      if (cmd.sqrt_step) begin
         rad_ff <= {rad_ff[RAD_BITS-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_ff  <= rem_diff[REM_BITS-1:0];
            root_ff <= {root_ff[ROOT_BITS-2:0], 1'b1};
         end else begin
            rem_ff  <= rem_sh[REM_BITS-1:0];
            root_ff <= {root_ff[ROOT_BITS-2:0], 1'b0};
         end
      end
      if (cmd.bend_load) begin
         // res * (1 + frac(pi/2)), rounded half up
         root_ff <= ROOT_BITS'(res_ff) + ROOT_BITS'(bend_sum[BEND_BITS-1:32]);
      end
      if (cmd.emit) begin
         rsp_len_ff <= total_ff;
         rsp_sat_ff <= clamp_ff;
      end
   end

   assign rsp_length_q16 = rsp_len_ff;
   assign rsp_saturated  = rsp_sat_ff;

   a_clamp_at_max: assert property (@(posedge clock) disable iff (reset)
      clamp_ff |-> (total_ff == TOTAL_MAX))
      else $error("clamp flag set with total below maximum");

   a_emit_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> ((total_ff == '0) && !clamp_ff && (points_ff == 2'd0)))
      else $error("path state not cleared after result");

endmodule

// File: design/gpl_ctrl.sv
// gpl_ctrl: sequencer for one path point and the response valid register.
// Depends on gpl_pkg; commands gpl_datapath.
module gpl_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  gpl_pkg::gpl_status_type  status,
   output gpl_pkg::gpl_cmd_type     cmd
);
   import gpl_pkg::*;

   gpl_state_type       state_ff, state_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            cmd.take_step = 1'b1;
            if (status.first_point || status.via) begin
               state_in = S_UPDATE;
            end else if (status.bend) begin
               state_in = S_BMUL;
            end else begin
               state_in = S_SQX;
            end
         end
         S_SQX: begin
            cmd.mul_sel = MUL_XX;
            state_in    = S_SQY;
         end
         S_SQY: begin
            cmd.mul_sel = MUL_YY;
            cmd.d2_load = 1'b1;
            state_in    = S_RR;
         end
         S_RR: begin
            cmd.mul_sel = MUL_RR;
            cmd.d2_add  = 1'b1;
            state_in    = S_NLO;
         end
         S_NLO: begin
            cmd.mul_sel   = MUL_NLO;
            cmd.res2_load = 1'b1;
            state_in      = S_NHI;
         end
         S_NHI: begin
            cmd.mul_sel = MUL_NHI;
            cmd.rad_lo  = 1'b1;
            state_in    = S_NACC;
         end
         S_NACC: begin
            cmd.rad_hi = 1'b1;
            cnt_in     = SQRT_LAST;
            state_in   = S_SQRT;
         end
         S_SQRT: begin
            cmd.sqrt_step = 1'b1;
            cnt_in        = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = S_ADD;
            end
         end
         S_BMUL: begin
            cmd.mul_sel = MUL_BEND;
            state_in    = S_BADD;
         end
         S_BADD: begin
            cmd.bend_load = 1'b1;
            state_in      = S_ADD;
         end
         S_ADD: begin
            cmd.add_step = 1'b1;
            state_in     = S_UPDATE;
         end
         S_UPDATE: begin
            if (!status.last_point) begin
               cmd.update = 1'b1;
               state_in   = S_IDLE;
            end else if (!rsp_valid_ff || rsp_ready) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten while held");

   a_sqrt_runs: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_SQRT) && (cnt_ff != '0)) |=> (state_ff == S_SQRT))
      else $error("square root left early");

   a_accept_decides: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_IDLE) && req_valid) |=> (state_ff == S_DECIDE))
      else $error("accepted request not classified");

endmodule

// File: design/grid_path_length_with_bends.sv
// grid_path_length_with_bends: top level, routed path length accumulator.
// Depends on gpl_pkg, gpl_ifs, gpl_ctrl and gpl_datapath.
//
// Use: points of a routed path arrive on req_bus (x, y, layer, last_point),
// one request per point. A layer change adds nothing, a turn between pure
// horizontal and pure vertical adds res * pi/2, any other step adds
// floor(res * euclidean step length). On the point marked last the total
// and its saturation flag go out on rsp_bus and the path state clears.
// Steps per request, from accept to req_ready high again:
//   first point or via: decide, update; bend: decide, bend multiply, bend add,
//   add, update; straight/diagonal: decide, five passes through the one 32x32
//   multiplier, radicand sum, the square root (one root bit per cycle), add,
//   update. One request is worked on at a time.
// A result sits in an output register; the next path is accepted while it
// waits. A last point only stalls if the previous result is still held.
// csr_we/csr_wdata write resolution_q16 (Q16); write it only while idle.
// Reset (synchronous, active high) sets resolution to 1.0, clears the path
// and drops rsp_bus.valid. No clearing pass is needed.
module grid_path_length_with_bends (
   input  logic                          clock,
   input  logic                          reset,
   gpl_req_if.sink                       req_bus,
   gpl_rsp_if.source                     rsp_bus,
   input  logic                          csr_we,
   input  logic [gpl_pkg::RES_BITS-1:0]  csr_wdata
);
   import gpl_pkg::*;

   gpl_cmd_type    cmd;
   gpl_status_type status;

   // sequencer: owns the handshakes and the response valid bit
   gpl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // arithmetic and path state
   gpl_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_x          (req_bus.x),
      .req_y          (req_bus.y),
      .req_layer      (req_bus.layer),
      .req_last_point (req_bus.last_point),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .rsp_length_q16 (rsp_bus.length_q16),
      .rsp_saturated  (rsp_bus.saturated)
   );

endmodule
